/* src/tftt_pkg.sv */
// shared types and constants for the touch frame trail tracker
package tftt_pkg;

    // trail and frame geometry
    localparam int TRAIL_LENGTH = 10;
    localparam int FRAME_LEN    = 7;
    localparam int BCNT_W       = $clog2(FRAME_LEN);

    localparam logic [7:0] FRAME_HEADER = 8'h68;
    localparam logic [7:0] TRAILER_BYTE = 8'hFF;

    // configuration registers
    localparam int DEADBAND_W = 8;
    localparam int TIMEOUT_W  = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'b1;

    localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 8'd2;
    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET  = 20'd5000;

    // idle counter saturates just above the largest timeout, same compare result
    localparam int                IDLE_W   = TIMEOUT_W + 1;
    localparam logic [IDLE_W-1:0] IDLE_SAT = IDLE_W'(1) << TIMEOUT_W;

    // input command codes
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // queue depths, powers of two
    localparam int OPQ_DEPTH  = 4;
    localparam int OPQ_AW     = $clog2(OPQ_DEPTH);
    localparam int RESQ_DEPTH = 4;
    localparam int RESQ_AW    = $clog2(RESQ_DEPTH);

    typedef enum logic [1:0] {
        ACT_ERASE = 2'd0,
        ACT_DRAW  = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        OP_FRAME = 2'd0,
        OP_TICK  = 2'd1,
        OP_CLEAR = 2'd2
    } op_kind_t;

    // classified operation from front to back
    typedef struct packed {
        op_kind_t           kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } op_t;

    // one result transaction
    typedef struct packed {
        action_t            action;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
    } res_t;

endpackage

/* src/tftt_front.sv */
// front end: frame parser and command classifier
module tftt_front
    import tftt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  command,
    input  logic [7:0]  byte_value,
    output logic        op_push,
    output op_t         op_data,
    input  logic        op_full
);

    localparam logic [BCNT_W-1:0] LAST_IDX = BCNT_W'(FRAME_LEN - 1);

    logic              in_frame_reg, in_frame_next;
    logic [BCNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]        frame_bytes_reg [0:FRAME_LEN-2];
    logic              accept;
    logic              trailer_ok;

    assign full   = op_full;
    assign accept = push && !op_full;

    // last byte arrives live, the other two trailer bytes are stored
    assign trailer_ok = (frame_bytes_reg[4] == TRAILER_BYTE) &&
                        (frame_bytes_reg[5] == TRAILER_BYTE) &&
                        (byte_value == TRAILER_BYTE);

    // parser next state and operation push
    always_comb
    begin
        in_frame_next   = in_frame_reg;
        byte_count_next = byte_count_reg;
        op_push         = 1'b0;
        op_data.kind    = OP_TICK;
        op_data.x       = {frame_bytes_reg[1], frame_bytes_reg[0]};
        op_data.y       = {frame_bytes_reg[3], frame_bytes_reg[2]};
        if (accept)
        begin
            unique case (command)
                CMD_BYTE:
                begin
                    if (!in_frame_reg)
                    begin
                        if (byte_value == FRAME_HEADER)
                        begin
                            in_frame_next   = 1'b1;
                            byte_count_next = '0;
                        end
                    end
                    else if (byte_count_reg == LAST_IDX)
                    begin
                        in_frame_next   = 1'b0;
                        byte_count_next = '0;
                        op_push         = trailer_ok;
                        op_data.kind    = OP_FRAME;
                    end
                    else
                    begin
                        byte_count_next = byte_count_reg + BCNT_W'(1);
                    end
                end
                CMD_TICK:
                begin
                    op_push      = 1'b1;
                    op_data.kind = OP_TICK;
                end
                CMD_CLEAR:
                begin
                    in_frame_next   = 1'b0;
                    byte_count_next = '0;
                    op_push         = 1'b1;
                    op_data.kind    = OP_CLEAR;
                end
                default:
                begin
                end
            endcase
        end
    end

    // parser control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            byte_count_reg <= '0;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            byte_count_reg <= byte_count_next;
        end
    end

    // frame byte capture
    always_ff @(posedge clk)
    begin
        if (accept && command == CMD_BYTE && in_frame_reg && byte_count_reg != LAST_IDX)
        begin
            frame_bytes_reg[byte_count_reg] <= byte_value;
        end
    end

    // byte position stays inside the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= LAST_IDX)
        else $error("byte count past end of frame");

    // an idle parser sits at position zero
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> byte_count_reg == '0)
        else $error("byte count nonzero outside a frame");

    // a clear request always leaves the parser waiting for a header
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == CMD_CLEAR) |=> !in_frame_reg)
        else $error("parser still in frame after clear");

endmodule

/* src/tftt_opq.sv */
// operation queue between front and back
module tftt_opq
    import tftt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_data,
    output logic full,
    input  logic pop,
    output op_t  pop_data,
    output logic empty
);

    op_t               mem [0:OPQ_DEPTH-1];
    logic [OPQ_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OPQ_AW:0]   count_reg;
    logic              do_push, do_pop;

    assign full     = (count_reg == (OPQ_AW+1)'(OPQ_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + OPQ_AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OPQ_AW'(1);
            end
            count_reg <= count_reg + (OPQ_AW+1)'(do_push) - (OPQ_AW+1)'(do_pop);
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // fill count never passes the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (OPQ_AW+1)'(OPQ_DEPTH))
        else $error("operation queue overflow");

    // pointers and count agree
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[OPQ_AW-1:0])
        else $error("operation queue pointers disagree with count");

    // an accepted push with no pop raises the count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + (OPQ_AW+1)'(1))
        else $error("operation queue count lost a push");

endmodule

/* src/tftt_back.sv */
// back end: trail, idle timer, configuration and result queue
module tftt_back
    import tftt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  op_empty,
    input  op_t                   op_data,
    output logic                  op_pop,
    output logic                  res_empty,
    input  logic                  res_pop,
    output res_t                  res_data
);

    localparam int CNT_W = RESQ_AW + 1;

    logic [DEADBAND_W-1:0]   deadband_reg;
    logic [TIMEOUT_W-1:0]    timeout_reg;
    logic [IDLE_W-1:0]       idle_reg, idle_next, idle_inc;
    logic                    drawn_reg, drawn_next;
    logic [TRAIL_LENGTH-1:0] valid_reg, valid_next;
    logic signed [15:0]      trail_x_reg [0:TRAIL_LENGTH-1];
    logic signed [15:0]      trail_y_reg [0:TRAIL_LENGTH-1];
    logic                    shift_en;

    res_t                    res_mem [0:RESQ_DEPTH-1];
    logic [RESQ_AW-1:0]      res_wr_reg, res_rd_reg;
    logic [CNT_W-1:0]        res_count_reg;
    logic [1:0]              n_res;
    res_t                    res0, res1;
    logic                    do_res_pop;

    logic signed [16:0]      dx, dy;
    logic [16:0]             abs_dx, abs_dy;
    logic                    take, timeout_hit;

    // take an operation only when two result slots are free
    assign op_pop     = !op_empty && (res_count_reg <= CNT_W'(RESQ_DEPTH - 2));
    assign res_empty  = (res_count_reg == '0);
    assign do_res_pop = res_pop && !res_empty;
    assign res_data   = res_mem[res_rd_reg];

    // movement test against newest trail point
    assign dx     = 17'(op_data.x) - 17'(trail_x_reg[TRAIL_LENGTH-1]);
    assign dy     = 17'(op_data.y) - 17'(trail_y_reg[TRAIL_LENGTH-1]);
    assign abs_dx = dx[16] ? 17'(-dx) : 17'(dx);
    assign abs_dy = dy[16] ? 17'(-dy) : 17'(dy);
    assign take   = !valid_reg[TRAIL_LENGTH-1] ||
                    (abs_dx > 17'(deadband_reg)) || (abs_dy > 17'(deadband_reg));

    // saturating idle count and timeout test
    assign idle_inc    = (idle_reg == IDLE_SAT) ? idle_reg : idle_reg + IDLE_W'(1);
    assign timeout_hit = drawn_reg && (idle_inc > IDLE_W'(timeout_reg));

    // operation execution
    always_comb
    begin
        valid_next = valid_reg;
        drawn_next = drawn_reg;
        idle_next  = idle_reg;
        shift_en   = 1'b0;
        n_res      = 2'd0;
        res0       = '{action: ACT_CLEAR, x: '0, y: '0, last: 1'b1};
        res1       = '{action: ACT_DRAW, x: op_data.x, y: op_data.y, last: 1'b1};
        if (op_pop)
        begin
            unique case (op_data.kind)
                OP_FRAME:
                begin
                    idle_next  = '0;
                    drawn_next = 1'b1;
                    if (take)
                    begin
                        shift_en   = 1'b1;
                        valid_next = {1'b1, valid_reg[TRAIL_LENGTH-1:1]};
                        if (valid_reg[0])
                        begin
                            res0  = '{action: ACT_ERASE, x: trail_x_reg[0],
                                      y: trail_y_reg[0], last: 1'b0};
                            n_res = 2'd2;
                        end
                        else
                        begin
                            res0  = res1;
                            n_res = 2'd1;
                        end
                    end
                end
                OP_TICK:
                begin
                    idle_next = idle_inc;
                    if (timeout_hit)
                    begin
                        drawn_next = 1'b0;
                        valid_next = '0;
                        n_res      = 2'd1;
                    end
                end
                OP_CLEAR:
                begin
                    drawn_next = 1'b0;
                    valid_next = '0;
                    n_res      = 2'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // control state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg  <= DEADBAND_RESET;
            timeout_reg   <= TIMEOUT_RESET;
            idle_reg      <= '0;
            drawn_reg     <= 1'b0;
            valid_reg     <= '0;
            res_wr_reg    <= '0;
            res_rd_reg    <= '0;
            res_count_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_DEADBAND: deadband_reg <= cfg_data[DEADBAND_W-1:0];
                    CFG_TIMEOUT:  timeout_reg  <= cfg_data[TIMEOUT_W-1:0];
                    default:      deadband_reg <= deadband_reg;
                endcase
            end
            idle_reg      <= idle_next;
            drawn_reg     <= drawn_next;
            valid_reg     <= valid_next;
            res_wr_reg    <= res_wr_reg + RESQ_AW'(n_res);
            if (do_res_pop)
            begin
                res_rd_reg <= res_rd_reg + RESQ_AW'(1);
            end
            res_count_reg <= res_count_reg + CNT_W'(n_res) - CNT_W'(do_res_pop);
        end
    end

    // trail shift line, slot zero oldest
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int i = 0; i < TRAIL_LENGTH - 1; i++)
            begin
                trail_x_reg[i] <= trail_x_reg[i+1];
                trail_y_reg[i] <= trail_y_reg[i+1];
            end
            trail_x_reg[TRAIL_LENGTH-1] <= op_data.x;
            trail_y_reg[TRAIL_LENGTH-1] <= op_data.y;
        end
    end

    // result queue storage, up to two writes per cycle
    always_ff @(posedge clk)
    begin
        if (n_res != 2'd0)
        begin
            res_mem[res_wr_reg] <= res0;
        end
        if (n_res == 2'd2)
        begin
            res_mem[res_wr_reg + RESQ_AW'(1)] <= res1;
        end
    end

    // result queue never overflows
    assert property (@(posedge clk) disable iff (!rst_n)
        res_count_reg <= CNT_W'(RESQ_DEPTH))
        else $error("result queue overflow");

    // a nonempty trail implies a drawn screen
    assert property (@(posedge clk) disable iff (!rst_n)
        (|valid_reg) |-> drawn_reg)
        else $error("trail holds points on a blank screen");

    // clear empties the trail and blanks the screen
    assert property (@(posedge clk) disable iff (!rst_n)
        (op_pop && op_data.kind == OP_CLEAR) |=> (valid_reg == '0 && !drawn_reg))
        else $error("clear left trail or screen state");

    // a good frame restarts the idle count and marks the screen drawn
    assert property (@(posedge clk) disable iff (!rst_n)
        (op_pop && op_data.kind == OP_FRAME) |=> (drawn_reg && idle_reg == '0))
        else $error("frame did not restart idle timer");

endmodule

/* src/touch_frame_trail_tracker.sv */
// top level of the touch frame trail tracker
//
//   channel   direction  handshake            payload
//   input     in         push / full          command, byte_value
//   result    out        empty / pop          action, point_x, point_y, last
//   config    in         cfg_write            cfg_index, cfg_data
//
// one input transaction per cycle sustained while full is low; a byte is parsed in the cycle it is taken
// the back end executes one operation per cycle while two result slots are free, writing up to two results
// an operation is registered in the operation queue, and its results in the result queue, before they show up
// reset clears parser, trail valid bits, idle timer and both queues; no clearing pass
// full rises when the four-entry operation queue fills; results wait in a four-entry queue
module touch_frame_trail_tracker
    import tftt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            command,
    input  logic [7:0]            byte_value,
    output logic                  empty,
    input  logic                  pop,
    output logic [1:0]            action,
    output logic signed [15:0]    point_x,
    output logic signed [15:0]    point_y,
    output logic                  last,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic op_push, op_full, op_pop, op_empty;
    op_t  op_in, op_out;
    res_t res;

    // parser and classifier
    tftt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .command    (command),
        .byte_value (byte_value),
        .op_push    (op_push),
        .op_data    (op_in),
        .op_full    (op_full)
    );

    // decoupling queue
    tftt_opq u_opq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (op_push),
        .push_data (op_in),
        .full      (op_full),
        .pop       (op_pop),
        .pop_data  (op_out),
        .empty     (op_empty)
    );

    // trail execution and results
    tftt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op_empty  (op_empty),
        .op_data   (op_out),
        .op_pop    (op_pop),
        .res_empty (empty),
        .res_pop   (pop),
        .res_data  (res)
    );

    // result fields
    assign action  = res.action;
    assign point_x = res.x;
    assign point_y = res.y;
    assign last    = res.last;

endmodule
